### design/sync_length_crc16_frame_parser_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sync / length / CRC-16 frame parser
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_CRC16_FRAME_PARSER_TOP_ASSERT_SVH
`define SYNC_LENGTH_CRC16_FRAME_PARSER_TOP_ASSERT_SVH

// same-cycle implication
`define SLCF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slcf assertion failed: same-cycle check");

// next-cycle implication
`define SLCF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slcf assertion failed: next-cycle check");

`endif

### design/slcf_pkg.sv
// ----------------------------------------------------------------------------
// slcf_pkg
// Types, codes and the byte-wise CRC-16 step for the frame parser.
// ----------------------------------------------------------------------------
package slcf_pkg;

    typedef enum logic [2:0] {
        PH_SYNC   = 3'd0,
        PH_SIZE_L = 3'd1,
        PH_SIZE_H = 3'd2,
        PH_CMD    = 3'd3,
        PH_DATA   = 3'd4,
        PH_CRC_L  = 3'd5,
        PH_CRC_H  = 3'd6
    } phase_t;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_ERR  = 2'd1;
    localparam logic [1:0] STATUS_DONE = 2'd2;

    localparam int unsigned ADDR_W = 5;

    localparam logic [2:0] REG_SYNC_VALUE  = 3'd0;
    localparam logic [2:0] REG_SIZE_OFFSET = 3'd1;
    localparam logic [2:0] REG_MAX_PAYLOAD = 3'd2;
    localparam logic [2:0] REG_CRC_POLY    = 3'd3;
    localparam logic [2:0] REG_CRC_START   = 3'd4;

    localparam logic [7:0]  SYNC_VALUE_RST  = 8'hAA;
    localparam logic [7:0]  SIZE_OFFSET_RST = 8'd1;
    localparam logic [15:0] MAX_PAYLOAD_RST = 16'd64;
    localparam logic [15:0] CRC_POLY_RST    = 16'hA001;
    localparam logic [15:0] CRC_START_RST   = 16'hFFFF;

    // Reflected CRC-16 over one byte: eight shift/xor rounds on the low byte.
    function automatic logic [15:0] crc_byte(
        input logic [15:0] crc,
        input logic [7:0]  data,
        input logic [15:0] poly
    );
        logic [15:0] t;
        t = {8'h00, crc[7:0] ^ data};
        for (int k = 0; k < 8; k++)
        begin
            if (t[0])
                t = (t >> 1) ^ poly;
            else
                t = t >> 1;
        end
        return t ^ {8'h00, crc[15:8]};
    endfunction

endpackage

### design/sync_length_crc16_frame_parser_top.sv
// An input transfer passes through the input register and then the result register.
// One byte per cycle unless out_stall holds; CRC step and phase update sit in one stage.
// Every accepted byte yields exactly one result transfer.
// Reset (rst_n, async, active low): hunting for sync, CRC = 0xFFFF, registers at defaults.
// ----------------------------------------------------------------------------
// sync_length_crc16_frame_parser_top
// Byte-wise receive parser for sync / size / command / payload / CRC-16 frames.
// ----------------------------------------------------------------------------
`include "sync_length_crc16_frame_parser_top_assert.svh"

module sync_length_crc16_frame_parser_top
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  rx_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  status,
    output logic [7:0]                  command,
    output logic                        payload_valid,
    output logic [7:0]                  payload_byte,
    output logic [15:0]                 payload_index,
    output logic [15:0]                 payload_count,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [slcf_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    import slcf_pkg::*;

    // configuration
    logic [7:0]  sync_value_reg;
    logic [7:0]  size_offset_reg;
    logic [15:0] max_payload_reg;
    logic [15:0] crc_poly_reg;
    logic [15:0] crc_start_reg;
    logic        cfg_write;
    logic [2:0]  cfg_index;

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        advance;

    // parser state
    phase_t      phase_reg, phase_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] size_reg, size_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [15:0] rcvd_reg, rcvd_next;

    // result register
    logic        out_valid_reg;
    logic [1:0]  status_reg, status_next;
    logic [7:0]  command_reg, command_next;
    logic        pv_reg, pv_next;
    logic [7:0]  pb_reg, pb_next;
    logic [15:0] pi_reg, pi_next;
    logic [15:0] pc_reg, pc_next;

    logic [15:0] crc_step;
    logic [15:0] size_full;
    logic [16:0] size_max;
    logic [16:0] rcvd_sum;

    // ------------------------------------------------------------------
    // APB register file
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_index = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_value_reg  <= SYNC_VALUE_RST;
            size_offset_reg <= SIZE_OFFSET_RST;
            max_payload_reg <= MAX_PAYLOAD_RST;
            crc_poly_reg    <= CRC_POLY_RST;
            crc_start_reg   <= CRC_START_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SYNC_VALUE:  sync_value_reg  <= pwdata[7:0];
                REG_SIZE_OFFSET: size_offset_reg <= pwdata[7:0];
                REG_MAX_PAYLOAD: max_payload_reg <= pwdata[15:0];
                REG_CRC_POLY:    crc_poly_reg    <= pwdata[15:0];
                REG_CRC_START:   crc_start_reg   <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_SYNC_VALUE:  prdata = {24'h0, sync_value_reg};
            REG_SIZE_OFFSET: prdata = {24'h0, size_offset_reg};
            REG_MAX_PAYLOAD: prdata = {16'h0, max_payload_reg};
            REG_CRC_POLY:    prdata = {16'h0, crc_poly_reg};
            REG_CRC_START:   prdata = {16'h0, crc_start_reg};
            default:         prdata = 32'h0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: input stage moves on whenever the result register frees up
    // ------------------------------------------------------------------
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_byte_reg <= rx_byte;
    end

    // ------------------------------------------------------------------
    // Frame parsing
    // ------------------------------------------------------------------
    assign crc_step  = crc_byte(crc_reg, in_byte_reg, crc_poly_reg);
    assign size_full = {in_byte_reg, size_reg[7:0]};
    assign size_max  = {1'b0, max_payload_reg} + {9'h0, size_offset_reg};
    assign rcvd_sum  = {1'b0, rcvd_reg + 16'd1} + {9'h0, size_offset_reg};

    always_comb
    begin
        phase_next   = phase_reg;
        crc_next     = crc_reg;
        size_next    = size_reg;
        cmd_next     = cmd_reg;
        rcvd_next    = rcvd_reg;
        status_next  = STATUS_OK;
        command_next = 8'h00;
        pv_next      = 1'b0;
        pb_next      = 8'h00;
        pi_next      = 16'h0000;
        pc_next      = 16'h0000;

        case (phase_reg)
            PH_SYNC:
            begin
                if (in_byte_reg == sync_value_reg)
                begin
                    phase_next = PH_SIZE_L;
                    crc_next   = crc_start_reg;
                    rcvd_next  = 16'h0000;
                end
            end
            PH_SIZE_L:
            begin
                size_next  = {8'h00, in_byte_reg};
                phase_next = PH_SIZE_H;
            end
            PH_SIZE_H:
            begin
                size_next = size_full;
                if (size_full >= {8'h00, size_offset_reg} && {1'b0, size_full} <= size_max)
                    phase_next = PH_CMD;
                else
                begin
                    phase_next  = PH_SYNC;
                    status_next = STATUS_ERR;
                end
            end
            PH_CMD:
            begin
                crc_next   = crc_step;
                cmd_next   = in_byte_reg;
                phase_next = (size_reg != {8'h00, size_offset_reg}) ? PH_DATA : PH_CRC_L;
            end
            PH_DATA:
            begin
                crc_next  = crc_step;
                pv_next   = 1'b1;
                pb_next   = in_byte_reg;
                pi_next   = rcvd_reg;
                rcvd_next = rcvd_reg + 16'd1;
                if (rcvd_sum >= {1'b0, size_reg})
                    phase_next = PH_CRC_L;
            end
            PH_CRC_L:
            begin
                crc_next   = crc_step;
                phase_next = PH_CRC_H;
            end
            PH_CRC_H:
            begin
                crc_next   = crc_step;
                phase_next = PH_SYNC;
                if (crc_step == 16'h0000)
                begin
                    status_next  = STATUS_DONE;
                    command_next = cmd_reg;
                    pc_next      = rcvd_reg;
                end
                else
                    status_next = STATUS_ERR;
            end
            default:
            begin
                phase_next  = PH_SYNC;
                status_next = STATUS_ERR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SYNC;
            crc_reg   <= 16'hFFFF;
            size_reg  <= 16'h0000;
            cmd_reg   <= 8'h00;
            rcvd_reg  <= 16'h0000;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            crc_reg   <= crc_next;
            size_reg  <= size_next;
            cmd_reg   <= cmd_next;
            rcvd_reg  <= rcvd_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg  <= status_next;
            command_reg <= command_next;
            pv_reg      <= pv_next;
            pb_reg      <= pb_next;
            pi_reg      <= pi_next;
            pc_reg      <= pc_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign command       = command_reg;
    assign payload_valid = pv_reg;
    assign payload_byte  = pb_reg;
    assign payload_index = pi_reg;
    assign payload_count = pc_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SLCF_ASSERT_NOW(a_pv_only_ok, out_valid_reg && pv_reg, status_reg == STATUS_OK)
    `SLCF_ASSERT_NEXT(a_crc_h_ends_frame, advance && phase_reg == PH_CRC_H, phase_reg == PH_SYNC)
    `SLCF_ASSERT_NEXT(a_data_gives_payload, advance && phase_reg == PH_DATA,
        out_valid_reg && pv_reg)
    `SLCF_ASSERT_NOW(a_stall_needs_result, in_stall, out_valid_reg && out_stall)

endmodule
